// File: rtl/core/mcarb_pkg.sv
// ----------------------------------------------------------------------------
// mcarb_pkg: shared types and constants for the multichannel audio ring buffer
// Field widths, operation and register codes, and the saturating sample add.
// ----------------------------------------------------------------------------
`default_nettype none

package mcarb_pkg;

    // Defaults for top level parameters
    localparam int RING_DEPTH_DEF = 8192;

    // Fixed field widths
    localparam int SAMPLE_BITS  = 24;
    localparam int MAX_CHANNELS = 2;
    localparam int DELAY_W      = 13;
    localparam int SRC_W        = 2;
    localparam int OP_W         = 2;
    localparam int RF_W         = 14;   // ring_frames register
    localparam int FC_W         = 2;    // frame_channels register
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = RF_W;

    localparam int IN_FIELD_W   = DELAY_W + SRC_W + 2 * SAMPLE_BITS;
    localparam int IN_TDATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    // Result queue, also the bound on reads in flight
    localparam int OUT_FIFO_DEPTH = 32;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_DUB   = 2'd1,
        OP_READ  = 2'd2
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RING_FRAMES    = 1'b0,
        REG_FRAME_CHANNELS = 1'b1
    } t_cfg_reg;

    // a + b clipped to the signed sample range
    function automatic t_sample sat_add(input t_sample a, input t_sample b);
        logic signed [SAMPLE_BITS:0] s;
        t_sample                     r;
        s = {a[SAMPLE_BITS-1], a} + {b[SAMPLE_BITS-1], b};
        if (s[SAMPLE_BITS] != s[SAMPLE_BITS-1]) begin
            r = s[SAMPLE_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                               : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else begin
            r = s[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/multichannel_audio_ring_buffer.sv
// ----------------------------------------------------------------------------
// multichannel_audio_ring_buffer: circular stereo frame store / delay line
// Write and dub (saturating add) items store a frame at the write position
// and advance it; read items return the frame delay_frames behind it.
// ----------------------------------------------------------------------------
//
//  port group  dir  handshake                fields (low bit up)
//  ----------  ---  -----------------------  ---------------------------------
//  s_axis      in   tvalid / tready          tuser: opcode
//                                            tdata: delay_frames,
//                                                   source_channels,
//                                                   sample_left, sample_right
//  m_axis      out  tvalid / tready          tdata: out_left, out_right
//  i_cfg       in   write enable, no wait    0 ring_frames, 1 frame_channels
//
//  One item per cycle sustained, except while the clearing pass, a fold
//  or a full set of read credits holds s_axis_tready low. A read passes
//  through the delay modulo unit: one remainder bit per stage over the
//  13 delay bits behind the input register, then a memory read stage and
//  the result queue write. After reset the frame memory is zeroed by a
//  clearing pass over all RING_DEPTH frames with s_axis_tready low. A write
//  to ring_frames folds the write position into the new length, also with
//  tready low. Up to OUT_FIFO_DEPTH reads may be in flight or queued; a
//  stalled m_axis only holds back s_axis once that queue is committed.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_audio_ring_buffer
    import mcarb_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input items
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // delay_frames[12:0], source_channels[14:13], sample_left[38:15],
    // sample_right[62:39], zero pad above
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode[1:0]
    input  wire logic [OP_W-1:0]        s_axis_tuser,
    // results
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // out_left[23:0], out_right[47:24]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // configuration
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int AW   = $clog2(RING_DEPTH);           // frame address
    localparam int LW   = $clog2(RING_DEPTH + 1);       // ring length
    localparam int CW   = (LW > RF_W) ? LW : RF_W;      // ring_frames register
    localparam int NSTG = DELAY_W;                      // modulo stages
    localparam int NCW  = $clog2(AW + 1);
    localparam int FAW  = $clog2(OUT_FIFO_DEPTH);
    localparam int FCW  = FAW + 1;
    localparam int FW   = 2 * SAMPLE_BITS;              // stored frame

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CW-1:0]   r_ring_frames;
    logic [FC_W-1:0] r_frame_ch;
    logic [LW-1:0]   len;
    logic            two_ch;
    logic            cfg_len_wr;

    assign cfg_len_wr = i_cfg_we && (t_cfg_reg'(i_cfg_addr) == REG_RING_FRAMES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_frames <= CW'(RING_DEPTH);
            r_frame_ch    <= FC_W'(MAX_CHANNELS);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                REG_RING_FRAMES:    r_ring_frames <= CW'(i_cfg_wdata);
                REG_FRAME_CHANNELS: r_frame_ch    <= i_cfg_wdata[FC_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective length: zero acts as one, above the store acts as the store
    always_comb begin
        if (r_ring_frames == '0) begin
            len = LW'(1);
        end else if (r_ring_frames > CW'(RING_DEPTH)) begin
            len = LW'(RING_DEPTH);
        end else begin
            len = LW'(r_ring_frames);
        end
    end

    assign two_ch = (r_frame_ch >= FC_W'(MAX_CHANNELS));

    // ------------------------------------------------------------------
    // Input unpack
    // ------------------------------------------------------------------
    t_opcode             in_op;
    logic [DELAY_W-1:0]  in_delay;
    logic [SRC_W-1:0]    in_src;
    t_sample             in_left;
    t_sample             in_right;
    t_sample             right_src;
    logic                in_fire;
    logic                in_is_read;
    logic                in_is_store;

    assign in_op     = t_opcode'(s_axis_tuser);
    assign in_delay  = s_axis_tdata[DELAY_W-1:0];
    assign in_src    = s_axis_tdata[DELAY_W +: SRC_W];
    assign in_left   = s_axis_tdata[DELAY_W + SRC_W +: SAMPLE_BITS];
    assign in_right  = s_axis_tdata[DELAY_W + SRC_W + SAMPLE_BITS +: SAMPLE_BITS];
    // one source channel (or a zero count) repeats the left sample
    assign right_src = (in_src >= SRC_W'(2)) ? in_right : in_left;

    assign in_fire     = s_axis_tvalid && s_axis_tready;
    assign in_is_read  = (in_op == OP_READ);
    assign in_is_store = (in_op == OP_DUB) || (in_op == OP_WRITE);

    // ------------------------------------------------------------------
    // Write position and its fold after a ring_frames change.
    // r_wp is the position as last advanced; a length change only folds
    // it into r_wpos, the position in use, so a later change folds from
    // the same r_wp again.
    // ------------------------------------------------------------------
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_wpos;
    logic           r_norm_busy;
    logic [NCW-1:0] r_norm_cnt;
    logic [LW-1:0]  r_norm_rem;
    logic [AW-1:0]  r_norm_src;
    logic [LW:0]    norm_sh;
    logic [LW-1:0]  norm_step;
    logic           norm_last;
    logic [LW-1:0]  wp_inc;
    logic [AW-1:0]  wp_next;

    assign norm_sh   = {r_norm_rem, r_norm_src[AW-1]};
    assign norm_step = (norm_sh >= {1'b0, len}) ? LW'(norm_sh - {1'b0, len})
                                                : LW'(norm_sh);
    assign norm_last = r_norm_busy && (r_norm_cnt == NCW'(1));
    assign wp_inc    = LW'(r_wpos) + LW'(1);
    assign wp_next   = (wp_inc == len) ? '0 : AW'(wp_inc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_busy <= 1'b0;
            r_norm_cnt  <= '0;
        end else if (cfg_len_wr) begin
            r_norm_busy <= 1'b1;
            r_norm_cnt  <= NCW'(AW);
        end else if (r_norm_busy) begin
            r_norm_cnt  <= r_norm_cnt - NCW'(1);
            if (norm_last) begin
                r_norm_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cfg_len_wr) begin
            r_norm_rem <= '0;
            r_norm_src <= r_wp;
        end else begin
            r_norm_rem <= norm_step;
            r_norm_src <= r_norm_src << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_wpos <= '0;
        end else if (norm_last) begin
            r_wpos <= AW'(norm_step);
        end else if (in_fire && in_is_store) begin
            r_wp   <= wp_next;
            r_wpos <= wp_next;
        end
    end

    // ------------------------------------------------------------------
    // Delay modulo pipeline: stage 0 is the input register, each stage
    // after it resolves one remainder bit of delay_frames mod length.
    // Every item rides through so memory accesses keep item order.
    // ------------------------------------------------------------------
    logic [NSTG:0]      r_v;
    logic [NSTG:0]      r_two;
    t_opcode            r_op   [NSTG+1];
    logic [AW-1:0]      r_pos  [NSTG+1];
    logic [LW-1:0]      r_plen [NSTG+1];
    logic [LW-1:0]      r_rem  [NSTG+1];
    logic [DELAY_W-1:0] r_dly  [NSTG+1];
    t_sample            r_s0   [NSTG+1];
    t_sample            r_s1   [NSTG+1];
    logic [LW:0]        step_sh  [NSTG];
    logic [LW-1:0]      step_rem [NSTG];

    always_comb begin
        for (int k = 0; k < NSTG; k++) begin
            step_sh[k]  = {r_rem[k], r_dly[k][DELAY_W-1-k]};
            step_rem[k] = (step_sh[k] >= {1'b0, r_plen[k]})
                        ? LW'(step_sh[k] - {1'b0, r_plen[k]})
                        : LW'(step_sh[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            // opcode three is taken and dropped here
            r_v <= {r_v[NSTG-1:0], in_fire && (in_is_read || in_is_store)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op[0]   <= in_op;
            r_pos[0]  <= r_wpos;
            r_plen[0] <= len;
            r_rem[0]  <= '0;
            r_dly[0]  <= in_delay;
            r_s0[0]   <= in_left;
            r_s1[0]   <= right_src;
            r_two[0]  <= two_ch;
        end
        for (int k = 0; k < NSTG; k++) begin
            r_op[k+1]   <= r_op[k];
            r_pos[k+1]  <= r_pos[k];
            r_plen[k+1] <= r_plen[k];
            r_rem[k+1]  <= step_rem[k];
            r_dly[k+1]  <= r_dly[k];
            r_s0[k+1]   <= r_s0[k];
            r_s1[k+1]   <= r_s1[k];
            r_two[k+1]  <= r_two[k];
        end
    end

    // Read address: position minus delay, wrapped into the ring
    logic [AW-1:0] mod_d;
    logic [AW-1:0] rd_addr;
    logic [LW:0]   wrap_sum;

    assign mod_d    = AW'(r_rem[NSTG]);
    assign wrap_sum = (LW+1)'(r_pos[NSTG]) + (LW+1)'(r_plen[NSTG]) - (LW+1)'(mod_d);

    always_comb begin
        if (r_op[NSTG] != OP_READ) begin
            rd_addr = r_pos[NSTG];
        end else if (r_pos[NSTG] >= mod_d) begin
            rd_addr = r_pos[NSTG] - mod_d;
        end else begin
            rd_addr = AW'(wrap_sum);
        end
    end

    // ------------------------------------------------------------------
    // Frame memory, clearing pass after reset
    // ------------------------------------------------------------------
    logic [FW-1:0] r_frame_mem [RING_DEPTH];
    logic [FW-1:0] r_rd_frame;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [FW-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(RING_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_frame_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_frame <= r_frame_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Merge stage: forward the previous cycle's write, then store or dub
    // ------------------------------------------------------------------
    logic          r_y_v;
    t_opcode       r_y_op;
    logic [AW-1:0] r_y_addr;
    t_sample       r_y_s0;
    t_sample       r_y_s1;
    logic          r_y_two;
    logic          r_lw_v;
    logic [AW-1:0] r_lw_addr;
    logic [FW-1:0] r_lw_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_v <= 1'b0;
        end else begin
            r_y_v <= r_v[NSTG];
        end
    end

    always_ff @(posedge i_clk) begin
        r_y_op   <= r_op[NSTG];
        r_y_addr <= rd_addr;
        r_y_s0   <= r_s0[NSTG];
        r_y_s1   <= r_s1[NSTG];
        r_y_two  <= r_two[NSTG];
    end

    logic [FW-1:0] old_frame;
    t_sample       old0;
    t_sample       old1;
    t_sample       new0;
    t_sample       new1;
    logic          y_write;
    logic          y_push;
    logic          y_dub;

    assign old_frame = (r_lw_v && (r_lw_addr == r_y_addr)) ? r_lw_data : r_rd_frame;
    assign old0      = old_frame[SAMPLE_BITS-1:0];
    assign old1      = old_frame[FW-1:SAMPLE_BITS];
    assign y_dub     = (r_y_op == OP_DUB);
    assign y_write   = r_y_v && (r_y_op != OP_READ);
    assign y_push    = r_y_v && (r_y_op == OP_READ);

    always_comb begin
        new0 = y_dub ? sat_add(old0, r_y_s0) : r_y_s0;
        if (!r_y_two) begin
            new1 = old1;                // channel not in use keeps its sample
        end else begin
            new1 = y_dub ? sat_add(old1, r_y_s1) : r_y_s1;
        end
    end

    always_comb begin
        if (r_clr_busy) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = y_write;
            mem_waddr = r_y_addr;
            mem_wdata = {new1, new0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw_v <= 1'b0;
        end else begin
            r_lw_v <= y_write;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lw_addr <= r_y_addr;
        r_lw_data <= {new1, new0};
    end

    // ------------------------------------------------------------------
    // Result queue and credit count
    // ------------------------------------------------------------------
    logic [OUT_TDATA_W-1:0] r_fifo [OUT_FIFO_DEPTH];
    logic [FAW-1:0]         r_head;
    logic [FAW-1:0]         r_tail;
    logic [FCW-1:0]         r_fcnt;
    logic [FCW-1:0]         r_used;
    logic                   pop;
    logic [FW-1:0]          res_frame;

    assign res_frame = {(r_y_two ? old1 : t_sample'(0)), old0};
    assign pop       = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (y_push) begin
            r_fifo[r_tail] <= OUT_TDATA_W'(res_frame);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fcnt <= '0;
            r_used <= '0;
        end else begin
            if (y_push) begin
                r_tail <= r_tail + FAW'(1);
            end
            if (pop) begin
                r_head <= r_head + FAW'(1);
            end
            r_fcnt <= r_fcnt + FCW'(y_push) - FCW'(pop);
            r_used <= r_used + FCW'(in_fire && in_is_read) - FCW'(pop);
        end
    end

    assign s_axis_tready = !r_clr_busy && !r_norm_busy
                        && (r_used < FCW'(OUT_FIFO_DEPTH));
    assign m_axis_tvalid = (r_fcnt != '0);
    assign m_axis_tdata  = r_fifo[r_head];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= FCW'(OUT_FIFO_DEPTH))
        else $error("read credits exceed result queue depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        y_push |-> (r_fcnt != FCW'(OUT_FIFO_DEPTH)))
        else $error("result pushed into full queue");

    a_pos_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_norm_busy |-> (LW'(r_wpos) < len))
        else $error("write position outside ring length");

    a_fold_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_len_wr |=> !s_axis_tready)
        else $error("input taken while position fold pending");

endmodule

`default_nettype wire

// File: tb/sv/audio_ring_checker.sv
// ----------------------------------------------------------------------------
// audio_ring_checker: frame store predictor and result comparator
// Watches the config port and both item channels of the ring buffer, keeps its
// own copy of the frame store, and checks every read result as it leaves.
// ----------------------------------------------------------------------------
module audio_ring_checker
    import mcarb_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    input  wire logic                   i_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  wire logic [OP_W-1:0]        i_s_axis_tuser,
    input  wire logic                   i_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    input  wire logic [OUT_TDATA_W-1:0] i_m_axis_tdata,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_items,
    output int                          o_results,
    output int                          o_clips
);

    localparam longint SAMPLE_TOP    = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_BOTTOM = -SAMPLE_TOP - 1;
    localparam logic [RF_W-1:0] RING_FRAMES_RESET = RF_W'(RING_DEPTH);

    // packed low field last: left sits in the low bits, as on the bus
    typedef struct packed {
        t_sample right;
        t_sample left;
    } t_frame;

    t_sample           frame_mem [RING_DEPTH][MAX_CHANNELS];
    int unsigned       head;
    logic [RF_W-1:0]   ring_frames_q;
    logic [FC_W-1:0]   frame_channels_q;
    t_frame            frames_due [$];
    int                fails, items, results, clips;

    function automatic int unsigned ring_len();
        if (ring_frames_q == 0) return 1;
        if (ring_frames_q > RING_DEPTH) return RING_DEPTH;
        return ring_frames_q;
    endfunction

    function automatic int unsigned lanes_in_use();
        if (frame_channels_q == 0) return 1;
        if (frame_channels_q > MAX_CHANNELS) return MAX_CHANNELS;
        return frame_channels_q;
    endfunction

    task automatic apply_frame_op(input logic [OP_W-1:0] op,
                                  input logic [IN_TDATA_W-1:0] data);
        int unsigned len, nch, pos, nsrc, d, idx;
        logic [DELAY_W-1:0] dly;
        logic [SRC_W-1:0]   src;
        t_sample            smp [2];
        t_sample            v;
        longint             sum;
        t_frame             want;
        dly    = data[DELAY_W-1:0];
        src    = data[DELAY_W +: SRC_W];
        smp[0] = data[DELAY_W + SRC_W +: SAMPLE_BITS];
        smp[1] = data[DELAY_W + SRC_W + SAMPLE_BITS +: SAMPLE_BITS];
        len    = ring_len();
        nch    = lanes_in_use();
        pos    = head % len;
        nsrc   = (src == 0) ? 1 : ((src > 2) ? 2 : src);
        case (op)
            OP_WRITE, OP_DUB: begin
                for (int c = 0; c < nch; c++) begin
                    v = smp[c % nsrc];
                    if (op == OP_DUB) begin
                        sum = longint'(frame_mem[pos][c]) + longint'(v);
                        if (sum > SAMPLE_TOP) begin
                            v = t_sample'(SAMPLE_TOP);
                            clips++;
                        end else if (sum < SAMPLE_BOTTOM) begin
                            v = t_sample'(SAMPLE_BOTTOM);
                            clips++;
                        end else begin
                            v = t_sample'(sum);
                        end
                    end
                    frame_mem[pos][c] = v;
                end
                head = (pos + 1) % len;
                items++;
            end
            OP_READ: begin
                d          = dly % len;
                idx        = (pos + len - d) % len;
                want.left  = frame_mem[idx][0];
                want.right = (nch > 1) ? frame_mem[idx][1] : '0;
                frames_due.push_back(want);
                items++;
            end
            default: ; // unused opcode: no effect
        endcase
    endtask

    always @(posedge i_clk) begin
        t_frame got, want;
        if (!i_rst_n) begin
            for (int k = 0; k < RING_DEPTH; k++) begin
                for (int c = 0; c < MAX_CHANNELS; c++) frame_mem[k][c] = '0;
            end
            head             = 0;
            ring_frames_q    = RING_FRAMES_RESET;
            frame_channels_q = FC_W'(MAX_CHANNELS);
            frames_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_RING_FRAMES:    ring_frames_q    = i_cfg_wdata[RF_W-1:0];
                    REG_FRAME_CHANNELS: frame_channels_q = i_cfg_wdata[FC_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                apply_frame_op(i_s_axis_tuser, i_s_axis_tdata);
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = i_m_axis_tdata[2*SAMPLE_BITS-1:0];
                if (frames_due.size() == 0) begin
                    $error("read result with no read waiting: left %0d right %0d",
                           got.left, got.right);
                    fails++;
                end else begin
                    want = frames_due.pop_front();
                    results++;
                    if (got.left !== want.left) begin
                        $error("out_left mismatch: expected %0d, got %0d",
                               want.left, got.left);
                        fails++;
                    end
                    if (got.right !== want.right) begin
                        $error("out_right mismatch: expected %0d, got %0d",
                               want.right, got.right);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= frames_due.size();
        o_items      <= items;
        o_results    <= results;
        o_clips      <= clips;
    end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the multichannel audio ring buffer
// Drives write, dub and read items through a range of ring lengths and
// channel counts, with bursty input and a stalling result sink; a separate
// checker predicts and compares every read result.
// ----------------------------------------------------------------------------
module testbench;
    import mcarb_pkg::*;

    // Opcode three is not part of the package enum; the block ignores it.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam t_sample SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // The slowest correct run is the clearing pass plus roughly 1000 items
    // with worst gaps and sink stalls.
    localparam int CYCLE_LIMIT     = 250000;
    // Writes land in the frame memory only after the modulo pipeline and the
    // merge stage; wait longer than that before touching config.
    localparam int DRAIN_CYCLES    = 2 * (DELAY_W + 3) + 8;
    localparam int HOLD_CYCLES     = 400;
    localparam int ITEMS_PER_PHASE = 93;
    localparam int NUM_PHASES      = 10;

    // Ring settings for the random part. Extremes: 0 (acts as 1), 1, 8192 and
    // 16383 (acts as 8192); channel counts 0 and 3 exercise the clamps. The
    // 8192 -> 5 step shrinks the ring below a write position that has moved on.
    int unsigned phase_ring  [NUM_PHASES] = '{16, 0, 1, 64, 16383, 7, 8192, 5, 3, 2};
    int unsigned phase_lanes [NUM_PHASES] = '{2, 2, 1, 3, 0, 2, 2, 1, 2, 1};

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   s_axis_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata   = '0;   // delay, source_channels, left, right
    logic [OP_W-1:0]        s_axis_tuser   = '0;   // opcode
    logic                   m_axis_tready  = 1'b0;
    logic                   i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_addr     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata    = '0;
    wire logic              s_axis_tready;
    wire logic              m_axis_tvalid;
    wire logic [OUT_TDATA_W-1:0] m_axis_tdata;  // out_left, out_right

    int  chk_fails, chk_pending, chk_items, chk_results, chk_clips;
    int  cycle_count;
    int  burst_left;     // items left in the current input burst
    bit  hold_req;       // asks the sink for its one long hold-off

    always #1 i_clk = ~i_clk;

    multichannel_audio_ring_buffer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    audio_ring_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_fail_count    (chk_fails),
        .o_pending       (chk_pending),
        .o_items         (chk_items),
        .o_results       (chk_results),
        .o_clips         (chk_clips)
    );

    // Watchdog: counts every cycle, including the clearing pass after reset.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reads still outstanding",
                     cycle_count, chk_pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result sink: stretches of always-ready, coin-flip, mostly-stalled and
    // mostly-ready, each of random length. Once asked, it cuts the stretch
    // short and holds tready low for a long stretch so the result queue
    // fills and the input side backs up.
    initial begin : result_sink
        int stretch;
        int mode;
        bit held;
        held = 1'b0;
        forever begin
            stretch = $urandom_range(4, 60);
            mode    = $urandom_range(0, 3);
            while (stretch > 0 && !(hold_req && !held)) begin
                stretch--;
                @(negedge i_clk);
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 4) != 0);
                endcase
            end
            if (hold_req && !held) begin
                held = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    m_axis_tready <= 1'b0;
                end
            end
        end
    end

    // Offer one item and wait for its handshake. Bursts of random length are
    // separated by random gaps; a gap of zero runs two bursts back to back.
    task automatic offer_item(input logic [OP_W-1:0]    op,
                              input logic [DELAY_W-1:0] dly,
                              input logic [SRC_W-1:0]   src,
                              input t_sample            left,
                              input t_sample            right);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_TDATA_W-IN_FIELD_W){1'b0}}, right, left, src, dly};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Drop valid, let every outstanding read come back, then give the
    // pipeline time to finish writes that produce no result.
    task automatic drain_block();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (chk_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input int unsigned value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Extremes often, so dubs saturate; otherwise small or full-range values.
    function automatic t_sample pick_sample();
        int roll;
        roll = $urandom_range(0, 7);
        case (roll)
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return t_sample'($signed($urandom_range(0, 2000)) - 1000);
            default: return t_sample'($urandom());
        endcase
    endfunction

    // Mostly short delays so reads land on recently written frames; the rest
    // full range or near the top, which wraps modulo the ring length.
    function automatic logic [DELAY_W-1:0] pick_delay();
        int roll;
        roll = $urandom_range(0, 3);
        case (roll)
            0, 1:    return DELAY_W'($urandom_range(0, 40));
            2:       return DELAY_W'($urandom());
            default: return DELAY_W'($urandom_range((1 << DELAY_W) - 48,
                                                    (1 << DELAY_W) - 1));
        endcase
    endfunction

    initial begin : stimulus
        int                 sent;
        int                 roll;
        logic [OP_W-1:0]    op;
        logic [SRC_W-1:0]   src;

        burst_left = 0;
        hold_req   = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reads of the cleared store at default config, delay 0 and
        // the largest delay; fields a read does not use set to all ones.
        offer_item(OP_READ, '0, '0, '0, '0);
        offer_item(OP_READ, '1, '1, '1, '1);
        drain_block();

        // Three-frame ring so dubs land on frames just written.
        write_reg(REG_FRAME_CHANNELS, 2);
        write_reg(REG_RING_FRAMES, 3);
        offer_item(OP_WRITE, 0, 2, SAMPLE_MAX, SAMPLE_MIN);
        offer_item(OP_WRITE, 0, 1, SAMPLE_MIN, 24'h123456);   // left copied right
        offer_item(OP_WRITE, 0, 0, -1, SAMPLE_MAX);           // zero sources acts as one
        offer_item(OP_READ, 0, 0, '0, '0);                    // oldest frame
        offer_item(OP_READ, 1, 0, '0, '0);
        offer_item(OP_READ, 2, 0, '0, '0);
        offer_item(OP_READ, 3, 0, '0, '0);                    // delay wraps to zero
        offer_item(OP_READ, '1, 0, '0, '0);                   // largest delay, wraps
        offer_item(OP_DUB, 0, 2, 1, -1);                      // clips high and low
        offer_item(OP_DUB, 0, 3, SAMPLE_MIN, SAMPLE_MAX);     // three sources acts as two
        offer_item(OP_DUB, 0, 0, 5, SAMPLE_MIN);
        offer_item(OP_UNUSED, '1, '1, '1, '1);                // ignored entirely
        offer_item(OP_READ, 0, 1, '0, '0);
        offer_item(OP_READ, 1, 1, '0, '0);
        offer_item(OP_READ, 2, 1, '0, '0);
        offer_item(OP_WRITE, 0, 3, '0, '1);
        offer_item(OP_READ, 1, 0, '0, '0);

        // Random part, one ring setting per phase. The hold-off phase is
        // read heavy so the result queue fills while the sink is held.
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_block();
            write_reg(REG_FRAME_CHANNELS, phase_lanes[p]);
            write_reg(REG_RING_FRAMES, phase_ring[p]);
            if (p == 1) hold_req = 1'b1;
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                roll = (p == 1) ? $urandom_range(62, 99) : $urandom_range(0, 99);
                if (roll < 40)      op = OP_WRITE;
                else if (roll < 62) op = OP_DUB;
                else if (roll < 95) op = OP_READ;
                else                op = OP_UNUSED;
                src = SRC_W'($urandom_range(0, 3));
                offer_item(op, pick_delay(), src, pick_sample(), pick_sample());
                if (op != OP_UNUSED) sent++;
            end
        end

        drain_block();
        $display("covered %0d items over %0d ring settings: %0d reads checked,",
                 chk_items, NUM_PHASES + 2, chk_results);
        $display("%0d clipped dub sums, one long sink hold-off", chk_clips);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/mcarb_pkg.sv
rtl/core/multichannel_audio_ring_buffer.sv
tb/sv/audio_ring_checker.sv
tb/sv/testbench.sv
